@@ sv/fit_scale_rotate_pixel_mapper_top_defines.svh @@
// ---------------------------------------------------------------------------
// fit_scale_rotate_pixel_mapper_top_defines
// assertion macros for the pixel mapper rtl
// ---------------------------------------------------------------------------
`ifndef FIT_SCALE_ROTATE_PIXEL_MAPPER_TOP_DEFINES_SVH
`define FIT_SCALE_ROTATE_PIXEL_MAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define FSRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fsrp_pkg.sv @@
// ---------------------------------------------------------------------------
// fsrp_pkg
// shared widths, register codes and types of the pixel mapper
// ---------------------------------------------------------------------------
`default_nettype none
package fsrp_pkg;

   localparam int PANEL_WIDTH_DEF    = 800;
   localparam int PANEL_HEIGHT_DEF   = 480;
   localparam int MAX_SOURCE_DIM_DEF = 2048;

   localparam int PX_W       = 10;
   localparam int PY_W       = 9;
   localparam int SX_W       = 11;
   localparam int IDX_W      = 22;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;
   localparam int MODE_W     = 2;

   // panel and fitted rectangle coordinates, up to 2048
   localparam int CRD_W  = 12;
   // source dimensions, up to 4096
   localparam int SRC_W  = 13;
   localparam int PROD_W = CRD_W + SRC_W;
   localparam int QUO_W  = SRC_W;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIT_MODE      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LANDSCAPE     = 4'd3;

   localparam logic [MODE_W-1:0] MODE_COVER    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONTAIN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ORIGINAL = 2'd2;

   typedef struct packed {
      logic [CRD_W-1:0] fit_left;
      logic [CRD_W-1:0] fit_top;
      logic [CRD_W-1:0] fit_width;
      logic [CRD_W-1:0] fit_height;
      logic [SRC_W-1:0] crop_left;
      logic [SRC_W-1:0] crop_top;
      logic [SRC_W-1:0] crop_width;
      logic [SRC_W-1:0] crop_height;
      logic [SRC_W-1:0] src_width;
      logic [SRC_W-1:0] src_height;
      logic             landscape;
   } fsrp_geom_type;

endpackage
`default_nettype wire

@@ sv/fit_scale_rotate_pixel_mapper_top.sv @@
// ---------------------------------------------------------------------------
// fit_scale_rotate_pixel_mapper_top
// nearest-neighbor panel to source pixel mapper with fit modes and rotation
// ---------------------------------------------------------------------------
// One panel pixel is taken per clock whenever busy is low, and its result
// appears on rsp_valid in order, one result per cycle; the receiver cannot
// stall, so results must be taken as they come. The pipeline is a chain of
// 13 division cells per axis, one quotient bit each, plus entry, multiply,
// offset and index stages. After reset and after every write to one of the
// four registers the block recomputes its fit and crop rectangles and holds
// busy high, using a shared bit-serial divider in cover and contain mode
// and skipping it in original mode; csr_ready is low during that time.
`default_nettype none
`include "fit_scale_rotate_pixel_mapper_top_defines.svh"
module fit_scale_rotate_pixel_mapper_top import fsrp_pkg::*; #(
   parameter int PANEL_WIDTH    = PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT   = PANEL_HEIGHT_DEF,
   parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PX_W-1:0]       req_panel_x,
   input  wire logic [PY_W-1:0]       req_panel_y,
   output logic                       rsp_valid,
   output logic                       rsp_inside_res,
   output logic [SX_W-1:0]            rsp_source_x,
   output logic [SX_W-1:0]            rsp_source_y,
   output logic [IDX_W-1:0]           rsp_source_index,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MUL_W = 2 * SRC_W + 1;

   fsrp_geom_type geom;

   fsrp_geom #(
      .PANEL_WIDTH    (PANEL_WIDTH),
      .PANEL_HEIGHT   (PANEL_HEIGHT),
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .geom_ff   (geom)
   );

   logic             accept;
   logic             off_panel, in_x, in_y, in_fit;
   logic [CRD_W-1:0] px, py, lx, ly;

   assign accept = start && !busy;

   always_comb begin
      px = CRD_W'(req_panel_x);
      py = CRD_W'(req_panel_y);
      off_panel = (px >= CRD_W'(PANEL_WIDTH)) || (py >= CRD_W'(PANEL_HEIGHT));
      // clockwise rotation of the logical frame onto the panel
      lx = geom.landscape ? py : px;
      ly = geom.landscape ? CRD_W'(PANEL_WIDTH - 1) - px : py;
      in_x = (lx >= geom.fit_left) &&
             ((CRD_W+1)'(lx) < (CRD_W+1)'(geom.fit_left) + (CRD_W+1)'(geom.fit_width));
      in_y = (ly >= geom.fit_top) &&
             ((CRD_W+1)'(ly) < (CRD_W+1)'(geom.fit_top) + (CRD_W+1)'(geom.fit_height));
      in_fit = !off_panel && (geom.fit_width != '0) && (geom.fit_height != '0) &&
               in_x && in_y;
   end

   // entry and multiply stages
   logic              v0_ff, in0_ff, v1_ff, in1_ff;
   logic [CRD_W-1:0]  dx0_ff, dy0_ff;
   logic [PROD_W-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
      end
      in0_ff  <= in_fit;
      dx0_ff  <= lx - geom.fit_left;
      dy0_ff  <= ly - geom.fit_top;
      in1_ff  <= in0_ff;
      numx_ff <= PROD_W'(dx0_ff) * PROD_W'(geom.crop_width);
      numy_ff <= PROD_W'(dy0_ff) * PROD_W'(geom.crop_height);
   end

   // division cell chains, most significant quotient bit first
   logic [PROD_W-1:0] rem_x [0:QUO_W];
   logic [PROD_W-1:0] rem_y [0:QUO_W];
   logic [QUO_W-1:0]  quo_x [0:QUO_W];
   logic [QUO_W-1:0]  quo_y [0:QUO_W];
   logic              vpipe_ff  [0:QUO_W-1];
   logic              inpipe_ff [0:QUO_W-1];

   assign rem_x[0] = numx_ff;
   assign rem_y[0] = numy_ff;
   assign quo_x[0] = '0;
   assign quo_y[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      fsrp_div_cell #(.BIT(QUO_W - 1 - k)) u_cell_x (
         .clock      (clock),
         .in_rem     (rem_x[k]),
         .in_quo     (quo_x[k]),
         .divisor    (geom.fit_width),
         .out_rem_ff (rem_x[k+1]),
         .out_quo_ff (quo_x[k+1])
      );
      fsrp_div_cell #(.BIT(QUO_W - 1 - k)) u_cell_y (
         .clock      (clock),
         .in_rem     (rem_y[k]),
         .in_quo     (quo_y[k]),
         .divisor    (geom.fit_height),
         .out_rem_ff (rem_y[k+1]),
         .out_quo_ff (quo_y[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) vpipe_ff[i] <= 1'b0;
      end else begin
         vpipe_ff[0] <= v1_ff;
         for (int i = 1; i < QUO_W; i++) vpipe_ff[i] <= vpipe_ff[i-1];
      end
      inpipe_ff[0] <= in1_ff;
      for (int i = 1; i < QUO_W; i++) inpipe_ff[i] <= inpipe_ff[i-1];
   end

   // offset and index stages
   logic             v2_ff, in2_ff;
   logic [SRC_W-1:0] sx_ff, sy_ff;
   logic [MUL_W-1:0] idx_full;

   assign idx_full = MUL_W'(sy_ff) * MUL_W'(geom.src_width) + MUL_W'(sx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v2_ff     <= vpipe_ff[QUO_W-1];
         rsp_valid <= v2_ff;
      end
      in2_ff           <= inpipe_ff[QUO_W-1];
      sx_ff            <= geom.crop_left + quo_x[QUO_W];
      sy_ff            <= geom.crop_top + quo_y[QUO_W];
      rsp_inside_res   <= in2_ff;
      rsp_source_x     <= in2_ff ? sx_ff[SX_W-1:0] : '0;
      rsp_source_y     <= in2_ff ? sy_ff[SX_W-1:0] : '0;
      rsp_source_index <= in2_ff ? idx_full[IDX_W-1:0] : '0;
   end

   `FSRP_ASSERT_IMP(a_outside_zero, clock, reset, rsp_valid && !rsp_inside_res, (rsp_source_x == '0) && (rsp_source_y == '0) && (rsp_source_index == '0), "outside transaction with nonzero source fields")
   `FSRP_ASSERT_IMP(a_inside_bounds, clock, reset, rsp_valid && rsp_inside_res, (SRC_W'(rsp_source_x) < geom.src_width) && (SRC_W'(rsp_source_y) < geom.src_height), "sampled pixel lies outside the source image")
   `FSRP_ASSERT_NXT(a_csr_recompute, clock, reset, csr_valid && csr_ready && (csr_index == REG_SOURCE_WIDTH || csr_index == REG_SOURCE_HEIGHT || csr_index == REG_FIT_MODE || csr_index == REG_LANDSCAPE), busy, "register write did not start a rectangle update")

endmodule
`default_nettype wire

@@ sv/fsrp_div_cell.sv @@
// ---------------------------------------------------------------------------
// fsrp_div_cell
// one restoring division step, settles one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module fsrp_div_cell import fsrp_pkg::*; #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic [PROD_W-1:0] in_rem,
   input  wire logic [QUO_W-1:0]  in_quo,
   input  wire logic [CRD_W-1:0]  divisor,
   output logic      [PROD_W-1:0] out_rem_ff,
   output logic      [QUO_W-1:0]  out_quo_ff
);

   logic [PROD_W-1:0] shifted;
   logic              take;
   logic [PROD_W-1:0] rem_in;
   logic [QUO_W-1:0]  quo_in;

   always_comb begin
      shifted = PROD_W'(divisor) << BIT;
      take    = in_rem >= shifted;
      rem_in  = take ? in_rem - shifted : in_rem;
      quo_in  = in_quo;
      quo_in[BIT] = take;
   end

   always_ff @(posedge clock) begin
      out_rem_ff <= rem_in;
      out_quo_ff <= quo_in;
   end

endmodule
`default_nettype wire

@@ sv/fsrp_geom.sv @@
// ---------------------------------------------------------------------------
// fsrp_geom
// configuration registers and sequential fit and crop rectangle solver
// ---------------------------------------------------------------------------
`default_nettype none
module fsrp_geom import fsrp_pkg::*; #(
   parameter int PANEL_WIDTH    = PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT   = PANEL_HEIGHT_DEF,
   parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       busy,
   output fsrp_geom_type              geom_ff
);

   localparam int CNT_W = $clog2(PROD_W);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_SETUP, ST_DIV, ST_DONE
   } state_type;

   state_type             state_ff;
   logic [CSR_DATA_W-1:0] src_w_ff, src_h_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic                  landscape_ff;
   logic [PROD_W-1:0]     p1_ff, p2_ff, num_ff;
   logic [SRC_W-1:0]      rem_ff, den_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [SRC_W-1:0]  w_c, h_c, rw_s, rh_s;
   logic [CRD_W-1:0]  rw, rh;
   logic [SRC_W:0]    trial, trial_sub;
   logic              sub_ok;
   logic [SRC_W-1:0]  quo;
   logic [CRD_W-1:0]  fw, fh;
   logic [SRC_W-1:0]  cw, ch;
   fsrp_geom_type     geom_in;

   always_comb begin
      if (src_w_ff == '0) w_c = SRC_W'(1);
      else if (SRC_W'(src_w_ff) > SRC_W'(MAX_SOURCE_DIM)) w_c = SRC_W'(MAX_SOURCE_DIM);
      else w_c = SRC_W'(src_w_ff);
      if (src_h_ff == '0) h_c = SRC_W'(1);
      else if (SRC_W'(src_h_ff) > SRC_W'(MAX_SOURCE_DIM)) h_c = SRC_W'(MAX_SOURCE_DIM);
      else h_c = SRC_W'(src_h_ff);
      // logical frame swaps axes in landscape
      rw   = landscape_ff ? CRD_W'(PANEL_HEIGHT) : CRD_W'(PANEL_WIDTH);
      rh   = landscape_ff ? CRD_W'(PANEL_WIDTH)  : CRD_W'(PANEL_HEIGHT);
      rw_s = SRC_W'(rw);
      rh_s = SRC_W'(rh);
      trial     = {rem_ff, num_ff[PROD_W-1]};
      sub_ok    = trial >= {1'b0, den_ff};
      trial_sub = trial - {1'b0, den_ff};
      quo       = num_ff[SRC_W-1:0];
   end

   always_comb begin
      fw = rw;
      fh = rh;
      cw = w_c;
      ch = h_c;
      case (mode_ff)
         MODE_CONTAIN: begin
            if (p1_ff <= p2_ff) fh = quo[CRD_W-1:0];
            else fw = quo[CRD_W-1:0];
         end
         MODE_COVER: begin
            if (p1_ff >= p2_ff) ch = quo;
            else cw = quo;
         end
         default: begin
            cw = (w_c < rw_s) ? w_c : rw_s;
            ch = (h_c < rh_s) ? h_c : rh_s;
            fw = CRD_W'(cw);
            fh = CRD_W'(ch);
         end
      endcase
      geom_in.fit_width   = fw;
      geom_in.fit_height  = fh;
      geom_in.fit_left    = (rw - fw) >> 1;
      geom_in.fit_top     = (rh - fh) >> 1;
      geom_in.crop_width  = cw;
      geom_in.crop_height = ch;
      geom_in.crop_left   = (w_c - cw) >> 1;
      geom_in.crop_top    = (h_c - ch) >> 1;
      geom_in.src_width   = w_c;
      geom_in.src_height  = h_c;
      geom_in.landscape   = landscape_ff;
   end

   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MUL1;
         src_w_ff     <= CSR_DATA_W'(1);
         src_h_ff     <= CSR_DATA_W'(1);
         mode_ff      <= MODE_COVER;
         landscape_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  state_ff <= ST_MUL1;
                  case (csr_index)
                     REG_SOURCE_WIDTH:  src_w_ff     <= csr_wdata;
                     REG_SOURCE_HEIGHT: src_h_ff     <= csr_wdata;
                     REG_FIT_MODE:      mode_ff      <= csr_wdata[MODE_W-1:0];
                     REG_LANDSCAPE:     landscape_ff <= csr_wdata[0];
                     default:           state_ff     <= ST_IDLE;
                  endcase
               end
            end
            ST_MUL1: begin
               p1_ff    <= PROD_W'(rw) * PROD_W'(h_c);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               p2_ff    <= PROD_W'(rh) * PROD_W'(w_c);
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(PROD_W - 1);
               state_ff <= ST_DIV;
               case (mode_ff)
                  MODE_CONTAIN: begin
                     num_ff <= (p1_ff <= p2_ff) ? p1_ff : p2_ff;
                     den_ff <= (p1_ff <= p2_ff) ? w_c : h_c;
                  end
                  MODE_COVER: begin
                     num_ff <= (p1_ff >= p2_ff) ? p2_ff : p1_ff;
                     den_ff <= (p1_ff >= p2_ff) ? rw_s : rh_s;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_DIV: begin
               rem_ff <= sub_ok ? trial_sub[SRC_W-1:0] : trial[SRC_W-1:0];
               num_ff <= {num_ff[PROD_W-2:0], sub_ok};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               geom_ff  <= geom_in;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks the pixel mapper against an integer predictor of the fit and crop
// rectangles, over all fit modes, both orientations and many source sizes
// ---------------------------------------------------------------------------
`default_nettype none

class pixel_map_scoreboard;
   typedef struct {
      logic             hit;
      logic [10:0]      sx;
      logic [10:0]      sy;
      logic [21:0]      sidx;
   } pixel_map_type;

   // configuration and derived rectangles
   int unsigned src_w_reg, src_h_reg, mode_reg, land_reg;
   longint fit_l, fit_t, fit_w, fit_h, crop_l, crop_t, crop_w, crop_h;
   pixel_map_type pending_maps[$];
   int errors;
   int checked;
   int inside_count;

   function new();
      errors = 0;
      checked = 0;
      inside_count = 0;
      src_w_reg = 1;
      src_h_reg = 1;
      mode_reg = fsrp_pkg::MODE_COVER;
      land_reg = 0;
      refit();
   endfunction

   function longint clamp_dim(int unsigned v);
      if (v < 1) return 1;
      if (v > 2048) return 2048;
      return v;
   endfunction

   function void refit();
      longint w, h, rw, rh;
      w = clamp_dim(src_w_reg);
      h = clamp_dim(src_h_reg);
      rw = land_reg ? 480 : 800;
      rh = land_reg ? 800 : 480;
      if (mode_reg == fsrp_pkg::MODE_CONTAIN) begin
         if (rw * h <= rh * w) begin
            fit_w = rw;
            fit_h = (h * rw) / w;
         end else begin
            fit_h = rh;
            fit_w = (w * rh) / h;
         end
         fit_l = (rw - fit_w) / 2;
         fit_t = (rh - fit_h) / 2;
         crop_l = 0;
         crop_t = 0;
         crop_w = w;
         crop_h = h;
      end else if (mode_reg == fsrp_pkg::MODE_COVER) begin
         fit_l = 0;
         fit_t = 0;
         fit_w = rw;
         fit_h = rh;
         if (rw * h >= rh * w) begin
            crop_w = w;
            crop_h = (rh * w) / rw;
         end else begin
            crop_h = h;
            crop_w = (rw * h) / rh;
         end
         crop_l = (w - crop_w) / 2;
         crop_t = (h - crop_h) / 2;
      end else begin
         crop_w = w < rw ? w : rw;
         crop_h = h < rh ? h : rh;
         crop_l = (w - crop_w) / 2;
         crop_t = (h - crop_h) / 2;
         fit_w = crop_w;
         fit_h = crop_h;
         fit_l = (rw - fit_w) / 2;
         fit_t = (rh - fit_h) / 2;
      end
   endfunction

   function void write_reg(logic [3:0] idx, logic [11:0] data);
      case (idx)
         fsrp_pkg::REG_SOURCE_WIDTH: src_w_reg = data;
         fsrp_pkg::REG_SOURCE_HEIGHT: src_h_reg = data;
         fsrp_pkg::REG_FIT_MODE: mode_reg = data[1:0];
         fsrp_pkg::REG_LANDSCAPE: land_reg = data[0];
         default: return;
      endcase
      refit();
   endfunction

   function void note_pixel(logic [9:0] px, logic [8:0] py);
      pixel_map_type m;
      longint lx, ly, sx, sy;
      m.hit = 0;
      m.sx = 0;
      m.sy = 0;
      m.sidx = 0;
      if (px < 800 && py < 480) begin
         lx = px;
         ly = py;
         if (land_reg) begin
            lx = py;
            ly = 799 - px;
         end
         if (fit_w > 0 && fit_h > 0 && lx >= fit_l && lx < fit_l + fit_w &&
             ly >= fit_t && ly < fit_t + fit_h) begin
            sy = crop_t + ((ly - fit_t) * crop_h) / fit_h;
            sx = crop_l + ((lx - fit_l) * crop_w) / fit_w;
            m.hit = 1;
            m.sx = sx[10:0];
            m.sy = sy[10:0];
            m.sidx = 22'(sy * clamp_dim(src_w_reg) + sx);
         end
      end
      pending_maps.push_back(m);
   endfunction

   function void check_pixel(logic ins, logic [10:0] sx, logic [10:0] sy, logic [21:0] sidx);
      pixel_map_type m;
      if (pending_maps.size() == 0) begin
         $display("%0t: unexpected result inside=%0d x=%0d y=%0d", $time, ins, sx, sy);
         errors++;
         return;
      end
      m = pending_maps.pop_front();
      checked++;
      if (m.hit) inside_count++;
      if (ins !== m.hit || sx !== m.sx || sy !== m.sy || sidx !== m.sidx) begin
         $display("%0t: mismatch expected inside=%0d x=%0d y=%0d idx=%0d actual %0d %0d %0d %0d",
                  $time, m.hit, m.sx, m.sy, m.sidx, ins, sx, sy, sidx);
         errors++;
      end
   endfunction
endclass

module testbench import fsrp_pkg::*; ();

   logic clock, reset, start, busy;
   logic [PX_W-1:0] req_panel_x;
   logic [PY_W-1:0] req_panel_y;
   logic rsp_valid, rsp_inside_res;
   logic [SX_W-1:0] rsp_source_x, rsp_source_y;
   logic [IDX_W-1:0] rsp_source_index;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_map_scoreboard pixel_sb;
   int pixels_sent;

   fit_scale_rotate_pixel_mapper_top DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         pixel_sb.check_pixel(rsp_inside_res, rsp_source_x, rsp_source_y, rsp_source_index);
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
      repeat (n) @(negedge clock);
   endtask

   // waits for all results, then for the tail of the pipeline
   task automatic drain();
      int guard;
      guard = 0;
      while (pixel_sb.pending_maps.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pixel_sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [1:0] m, logic l);
      drain();
      write_csr(REG_SOURCE_WIDTH, w);
      write_csr(REG_SOURCE_HEIGHT, h);
      write_csr(REG_FIT_MODE, {10'd0, m});
      write_csr(REG_LANDSCAPE, {11'd0, l});
   endtask

   // holds start until the transaction is taken; start stays high for back-to-back
   task automatic send_pixel(logic [PX_W-1:0] px, logic [PY_W-1:0] py, bit keep);
      start <= 1;
      req_panel_x <= px;
      req_panel_y <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixel_sb.note_pixel(px, py);
      pixels_sent++;
      @(negedge clock);
      if (!keep) start <= 0;
   endtask

   task automatic random_pixel();
      logic [PX_W-1:0] px;
      logic [PY_W-1:0] py;
      bit gap;
      px = ($urandom_range(0, 15) == 0) ? PX_W'($urandom_range(0, 1023))
                                        : PX_W'($urandom_range(0, 799));
      py = ($urandom_range(0, 15) == 0) ? PY_W'($urandom_range(0, 511))
                                        : PY_W'($urandom_range(0, 479));
      gap = $urandom_range(0, 3) == 0;
      send_pixel(px, py, !gap);
      if (gap) idle_gap();
   endtask

   initial begin
      logic [11:0] dims[] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd480, 12'd800, 12'd2047,
                              12'd2048, 12'd2049, 12'd4095, 12'd640, 12'd37};
      logic [11:0] w, h;
      pixel_sb = new();
      pixels_sent = 0;
      reset = 1;
      start = 0;
      req_panel_x = 0;
      req_panel_y = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      repeat (2) @(negedge clock);
      reset = 0;

      // reset geometry: 1x1 source, cover
      send_pixel(10'd0, 9'd0, 1);
      send_pixel(10'd799, 9'd479, 1);
      send_pixel(10'd1023, 9'd0, 1);
      send_pixel(10'd0, 9'd511, 0);

      // each fit mode, including the unused code, in both orientations
      for (int m = 0; m < 4; m++) begin
         for (int l = 0; l < 2; l++) begin
            set_geometry(12'd1024, 12'd300, m[1:0], l[0]);
            send_pixel(10'd0, 9'd0, 1);
            send_pixel(10'd799, 9'd479, 1);
            send_pixel(10'd400, 9'd240, 0);
         end
      end

      // random phases over a spread of source sizes
      for (int phase = 0; phase < 24; phase++) begin
         w = ($urandom_range(0, 2) == 0) ? dims[$urandom_range(0, dims.size() - 1)]
                                         : 12'($urandom_range(0, 4095));
         h = ($urandom_range(0, 2) == 0) ? dims[$urandom_range(0, dims.size() - 1)]
                                         : 12'($urandom_range(0, 4095));
         set_geometry(w, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         repeat (26) random_pixel();
         start <= 0;
         if (phase == 5) drain();
      end

      drain();
      $display("sent %0d pixels, mapped %0d (%0d inside the fitted image)",
               pixels_sent, pixel_sb.checked, pixel_sb.inside_count);
      $display("over cover, contain and original in both orientations, sources 0 to 4095");
      if (pixel_sb.errors == 0 && pixel_sb.pending_maps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
